[rtl/ert_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the echo round-trip tracker.
// No dependencies; used by the tracker and its testbench.
package ert_pkg;

  localparam int unsigned MS_PER_TICK = 10;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_REPLY  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] dst_addr;
    logic [15:0] identifier;
    logic [15:0] sequence_req;
    logic [31:0] now_ticks;
    logic [3:0]  read_slot;
  } ert_in_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        matched;
    logic [31:0] rtt_ms;
    logic [31:0] entry_dst;
    logic [15:0] entry_identifier;
    logic [15:0] entry_sequence;
    logic [31:0] entry_send_ms;
    logic [31:0] entry_recv_ms;
    logic        entry_received;
    logic [4:0]  entry_count;
  } ert_out_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [15:0] identifier;
    logic [15:0] sequence_nr;
    logic [31:0] send_ms;
    logic [31:0] recv_ms;
    logic [31:0] rtt;
    logic        received;
  } ert_rec_t;

endpackage

[rtl/ert_chan_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item of type T.
// Payload types come from ert_pkg at the point of instantiation.
interface ert_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/echo_rtt_tracker.sv]
`timescale 1ns / 1ps
// Echo round-trip tracker: ring table of outstanding echo requests.
// Depends on ert_pkg, ert_chan_if and ert_ram.
//
// The block holds TABLE_DEPTH slots in one RAM with a single read port and
// registered read data. Record and no-operation items, a read of an unwritten
// slot and a reply to an empty table have a valid result in the cycle after
// acceptance. A read of a written slot passes through the read state before
// its result is registered. A reply scans the written slots from slot 0
// through that read port, one slot per cycle. The input is not ready from
// acceptance until the result has been taken, and it is ready again in the
// cycle after that. A slot at or above the fill count counts as unwritten and
// reads as zero, so no clearing pass runs after reset.
module echo_rtt_tracker #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ert_chan_if.sink   in_i,
  ert_chan_if.source out_o
);
  import ert_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] wp_q, wp_d;
  logic [CntW-1:0] filled_q, filled_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     id_q, id_d;
  logic [15:0]     seq_q, seq_d;
  logic [31:0]     now_q, now_d;
  logic [3:0]      rslot_q, rslot_d;
  ert_out_t        out_q, out_d;
  logic            out_load;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  ert_rec_t        ram_wdata, ram_rdata;

  logic            accept;
  logic [31:0]     in_now_ms;
  logic [31:0]     wp_ext, idx_ext, cnt_ext;
  logic [CntW-1:0] idx_next;
  logic            rd_written;
  logic            hit;
  ert_rec_t        rec_new, rec_upd;

  ert_ram #(
    .WIDTH ($bits(ert_rec_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept     = in_i.valid && in_i.ready;
  assign in_now_ms  = (in_i.data.now_ticks << 3) + (in_i.data.now_ticks << 1);
  assign wp_ext     = 32'(wp_q);
  assign idx_ext    = 32'(idx_q);
  assign cnt_ext    = 32'(filled_d);
  assign idx_next   = CntW'(idx_q) + CntW'(1);
  assign rd_written = 32'(in_i.data.read_slot) < 32'(filled_q);

  assign hit = !ram_rdata.received && (ram_rdata.identifier == id_q) &&
               (ram_rdata.sequence_nr == seq_q);

  always_comb begin
    rec_new             = '0;
    rec_new.dst         = in_i.data.dst_addr;
    rec_new.identifier  = in_i.data.identifier;
    rec_new.sequence_nr = in_i.data.sequence_req;
    rec_new.send_ms     = in_now_ms;
    rec_upd             = ram_rdata;
    rec_upd.recv_ms     = now_q;
    rec_upd.rtt         = now_q - ram_rdata.send_ms;
    rec_upd.received    = 1'b1;
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    filled_d  = filled_q;
    idx_d     = idx_q;
    id_d      = id_q;
    seq_d     = seq_q;
    now_d     = now_q;
    rslot_d   = rslot_q;
    out_d     = '0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wp_q;
    ram_wdata = rec_new;
    ram_re    = 1'b0;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d    = in_i.data.identifier;
          seq_d   = in_i.data.sequence_req;
          now_d   = in_now_ms;
          rslot_d = in_i.data.read_slot;
          idx_d   = '0;
          unique case (in_i.data.cmd)
            CMD_RECORD: begin
              ram_we                 = 1'b1;
              out_load               = 1'b1;
              out_d.slot             = wp_ext[3:0];
              out_d.entry_dst        = rec_new.dst;
              out_d.entry_identifier = rec_new.identifier;
              out_d.entry_sequence   = rec_new.sequence_nr;
              out_d.entry_send_ms    = rec_new.send_ms;
              wp_d = (wp_q == IdxW'(TABLE_DEPTH - 1)) ? '0 : wp_q + IdxW'(1);
              if (filled_q != CntW'(TABLE_DEPTH)) begin
                filled_d = filled_q + CntW'(1);
              end
              state_d = S_OUT;
            end
            CMD_REPLY: begin
              if (filled_q == '0) begin
                out_load = 1'b1;
                state_d  = S_OUT;
              end else begin
                ram_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
            CMD_READ: begin
              if (rd_written) begin
                ram_re    = 1'b1;
                ram_raddr = IdxW'(in_i.data.read_slot);
                state_d   = S_READ;
              end else begin
                out_load   = 1'b1;
                out_d.slot = in_i.data.read_slot;
                state_d    = S_OUT;
              end
            end
            default: begin
              out_load = 1'b1;
              state_d  = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          ram_we                 = 1'b1;
          ram_waddr              = idx_q;
          ram_wdata              = rec_upd;
          out_load               = 1'b1;
          out_d.slot             = idx_ext[3:0];
          out_d.matched          = 1'b1;
          out_d.rtt_ms           = rec_upd.rtt;
          out_d.entry_dst        = rec_upd.dst;
          out_d.entry_identifier = rec_upd.identifier;
          out_d.entry_sequence   = rec_upd.sequence_nr;
          out_d.entry_send_ms    = rec_upd.send_ms;
          out_d.entry_recv_ms    = rec_upd.recv_ms;
          out_d.entry_received   = 1'b1;
          state_d                = S_OUT;
        end else if (idx_next >= filled_q) begin
          out_load = 1'b1;
          state_d  = S_OUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = IdxW'(idx_next);
          idx_d     = IdxW'(idx_next);
        end
      end
      S_READ: begin
        out_load               = 1'b1;
        out_d.slot             = rslot_q;
        out_d.rtt_ms           = ram_rdata.rtt;
        out_d.entry_dst        = ram_rdata.dst;
        out_d.entry_identifier = ram_rdata.identifier;
        out_d.entry_sequence   = ram_rdata.sequence_nr;
        out_d.entry_send_ms    = ram_rdata.send_ms;
        out_d.entry_recv_ms    = ram_rdata.recv_ms;
        out_d.entry_received   = ram_rdata.received;
        state_d                = S_OUT;
      end
      S_OUT: begin
        if (out_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_d.entry_count = cnt_ext[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      filled_q <= '0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      filled_q <= filled_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    seq_q   <= seq_d;
    now_q   <= now_d;
    rslot_q <= rslot_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = (state_q == S_OUT);
  assign out_o.data  = out_q;

  a_one_side_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  a_match_marks_received: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.matched) |-> out_o.data.entry_received)
    else $error("matched result without received mark");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CntW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_scan_in_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (32'(idx_q) < 32'(filled_q)))
    else $error("scan beyond written slots");

endmodule

[rtl/ert_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ert_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[dv/echo_rtt_tracker_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for echo_rtt_tracker: directed and random echo traffic
// checked item by item against a table predictor kept here.
// Depends on ert_pkg, ert_chan_if and the echo_rtt_tracker RTL.
module echo_rtt_tracker_test;
  import ert_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ert_chan_if #(.T(ert_in_t))  in_if ();
  ert_chan_if #(.T(ert_out_t)) out_if ();

  echo_rtt_tracker #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  ert_rec_t    slot_mem [DEPTH];
  int unsigned wr_ptr;
  int unsigned fill_cnt;
  ert_out_t    slot_reports_q[$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned replies_matched;

  function automatic ert_out_t slot_view(int unsigned s);
    ert_out_t res;
    res                  = '0;
    res.slot             = s[3:0];
    res.rtt_ms           = slot_mem[s].rtt;
    res.entry_dst        = slot_mem[s].dst;
    res.entry_identifier = slot_mem[s].identifier;
    res.entry_sequence   = slot_mem[s].sequence_nr;
    res.entry_send_ms    = slot_mem[s].send_ms;
    res.entry_recv_ms    = slot_mem[s].recv_ms;
    res.entry_received   = slot_mem[s].received;
    return res;
  endfunction

  function automatic ert_out_t echo_table_update(ert_in_t it);
    ert_out_t    res;
    logic [31:0] now_ms;
    int unsigned s;
    bit          hit;
    res    = '0;
    now_ms = it.now_ticks * 32'(MS_PER_TICK);
    hit    = 1'b0;
    case (it.cmd)
      CMD_RECORD: begin
        s = wr_ptr;
        slot_mem[s]             = '0;
        slot_mem[s].dst         = it.dst_addr;
        slot_mem[s].identifier  = it.identifier;
        slot_mem[s].sequence_nr = it.sequence_req;
        slot_mem[s].send_ms     = now_ms;
        wr_ptr = (s + 1 >= DEPTH) ? 0 : s + 1;
        if (fill_cnt < DEPTH) fill_cnt++;
        res = slot_view(s);
      end
      CMD_REPLY: begin
        for (int unsigned k = 0; k < fill_cnt; k++) begin
          if (!hit && !slot_mem[k].received && slot_mem[k].identifier == it.identifier &&
              slot_mem[k].sequence_nr == it.sequence_req) begin
            slot_mem[k].recv_ms  = now_ms;
            slot_mem[k].rtt      = now_ms - slot_mem[k].send_ms;
            slot_mem[k].received = 1'b1;
            res         = slot_view(k);
            res.matched = 1'b1;
            hit         = 1'b1;
          end
        end
        if (hit) replies_matched++;
      end
      CMD_READ: begin
        res      = slot_view(it.read_slot);
        res.slot = it.read_slot;
      end
      default: begin
      end
    endcase
    res.entry_count = fill_cnt[4:0];
    return res;
  endfunction

  function automatic ert_in_t make_item(logic [1:0] cmd, logic [31:0] dst, logic [15:0] id,
                                        logic [15:0] seq, logic [31:0] ticks, logic [3:0] rd);
    ert_in_t it;
    it.cmd          = cmd;
    it.dst_addr     = dst;
    it.identifier   = id;
    it.sequence_req = seq;
    it.now_ticks    = ticks;
    it.read_slot    = rd;
    return it;
  endfunction

  function automatic ert_in_t random_echo_item();
    ert_in_t     it;
    int unsigned pick;
    int unsigned k;
    it.dst_addr     = $urandom;
    it.identifier   = 16'($urandom);
    it.sequence_req = 16'($urandom);
    it.now_ticks    = $urandom;
    it.read_slot    = 4'($urandom_range(15));
    if ($urandom_range(7) == 0) it.now_ticks = 32'hFFFF_FFFF - $urandom_range(1000);
    pick = $urandom_range(99);
    if (pick < 40) begin
      it.cmd = CMD_RECORD;
      if ($urandom_range(1) == 1) begin
        it.identifier   = 16'($urandom_range(3));
        it.sequence_req = 16'($urandom_range(7));
      end
    end else if (pick < 78) begin
      it.cmd = CMD_REPLY;
      if (fill_cnt != 0 && $urandom_range(4) != 0) begin
        k               = $urandom_range(fill_cnt - 1);
        it.identifier   = slot_mem[k].identifier;
        it.sequence_req = slot_mem[k].sequence_nr;
      end else if ($urandom_range(1) == 1) begin
        it.identifier   = 16'($urandom_range(3));
        it.sequence_req = 16'($urandom_range(7));
      end
    end else if (pick < 95) begin
      it.cmd = CMD_READ;
    end else begin
      it.cmd = CMD_NOP;
    end
    return it;
  endfunction

  task automatic send_item(ert_in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    slot_reports_q.push_back(echo_table_update(it));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (slot_reports_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endtask

  task automatic check_report(ert_out_t want, ert_out_t got);
    note_field("slot", 32'(want.slot), 32'(got.slot));
    note_field("matched", 32'(want.matched), 32'(got.matched));
    note_field("rtt_ms", want.rtt_ms, got.rtt_ms);
    note_field("entry_dst", want.entry_dst, got.entry_dst);
    note_field("entry_identifier", 32'(want.entry_identifier), 32'(got.entry_identifier));
    note_field("entry_sequence", 32'(want.entry_sequence), 32'(got.entry_sequence));
    note_field("entry_send_ms", want.entry_send_ms, got.entry_send_ms);
    note_field("entry_recv_ms", want.entry_recv_ms, got.entry_recv_ms);
    note_field("entry_received", 32'(want.entry_received), 32'(got.entry_received));
    note_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (slot_reports_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, got %p", $time, out_if.data);
        end else begin
          check_report(slot_reports_q.pop_front(), out_if.data);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL echo_rtt_tracker");
        $finish;
      end
    end
  end

  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_item(make_item(CMD_READ, '0, '0, '0, '0, 4'd0));
    send_item(make_item(CMD_READ, '0, '0, '0, '0, 4'd15));
    // zero id/seq must not hit the unwritten slots of the empty table
    send_item(make_item(CMD_REPLY, '0, '0, '0, 32'd5, '0));
    send_item(make_item(CMD_NOP, '1, '1, '1, '1, '1));
    send_item(make_item(CMD_RECORD, '1, '1, '1, '1, '1));
    send_item(make_item(CMD_RECORD, '0, '0, '0, '0, '0));
    send_item(make_item(CMD_RECORD, 32'h0A00_0001, 16'h1234, 16'd1, 32'd100, '0));
    send_item(make_item(CMD_RECORD, 32'hC0A8_0101, 16'h1234, 16'd1, 32'd200, '0));
    send_item(make_item(CMD_REPLY, '0, 16'h1234, 16'd1, 32'd150, '0));
    send_item(make_item(CMD_REPLY, '0, 16'h1234, 16'd1, 32'd250, '0));
    send_item(make_item(CMD_REPLY, '0, 16'h1234, 16'd1, 32'd300, '0));
    send_item(make_item(CMD_REPLY, '1, '0, '0, 32'h1999_999A, '1));
    send_item(make_item(CMD_REPLY, '0, '1, '1, '0, '0));
    send_item(make_item(CMD_REPLY, '0, 16'h1234, 16'd2, 32'd400, '0));
    for (int i = 0; i < 5; i++) send_item(make_item(CMD_READ, '0, '0, '0, '0, 4'(i)));
    send_item(make_item(CMD_NOP, '0, '0, '0, '0, '0));
    wait_drained();
  endtask

  task automatic test_random(int unsigned src_pct, int unsigned snk_pct, int unsigned n);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int unsigned i = 0; i < n; i++) send_item(random_echo_item());
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) send_item(random_echo_item());
    wait_drained();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    wr_ptr       = 0;
    fill_cnt     = 0;
    hold_left    = 0;
    for (int i = 0; i < DEPTH; i++) slot_mem[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(0, 0, 430);
    test_random(80, 0, 430);
    test_random(0, 80, 430);
    test_backpressure();
    test_random(23, 23, 430);

    repeat (DEPTH + 4) @(posedge clk_i);
    $display("Sent %0d items, checked %0d results, %0d replies matched a pending slot.",
             items_sent, results_seen, replies_matched);
    $display("Phases: directed, free-running, sender gaps, receiver stalls, long hold, mixed.");
    if (fail_count == 0 && slot_reports_q.size() == 0) begin
      $display("PASS echo_rtt_tracker");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count, slot_reports_q.size());
      $display("FAIL echo_rtt_tracker");
    end
    $finish;
  end

endmodule
